### hdl/comp_pkg.sv
// ----------------------------------------------------------------------------
// comp_pkg
// shared widths, mode codes and the arctangent table of the compass block
// ----------------------------------------------------------------------------
package comp_pkg;

    localparam int MAG_W    = 16;  // raw sample width
    localparam int SCALE_W  = 16;  // axis scale width
    localparam int OFFD_W   = 17;  // doubled offset width
    localparam int RANGE_W  = 16;  // positive axis range width
    localparam int SUM_W    = 18;  // sum of three ranges
    localparam int DEN_W    = 19;  // six times one range
    localparam int CAL_W    = 18;  // twice raw minus doubled offset
    localparam int PROD_W   = 34;  // calibrated value
    localparam int CORD_W   = 37;  // cordic vector with growth headroom
    localparam int ANG_W    = 32;  // binary angle
    localparam int HEAD_W   = 15;  // heading output
    localparam int ATAN_LEN = 24;
    localparam int STEP_W   = 5;   // index into the arctangent table
    localparam int MCNT_W   = 4;   // multiplier bit counter

    localparam logic [HEAD_W-1:0] HEADING_TURN = 15'd23040;
    localparam logic [ANG_W-1:0]  HALF_TURN    = 32'h8000_0000;
    localparam logic [SCALE_W-1:0] SCALE_TOP   = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_SAMPLE  = 2'd1,
        MODE_FINISH  = 2'd2,
        MODE_HEADING = 2'd3
    } t_mode;

    typedef logic [ANG_W-1:0] t_atan_tab [ATAN_LEN];

    localparam t_atan_tab ATAN_TURNS = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

### hdl/comp_in_if.sv
// ----------------------------------------------------------------------------
// comp_in_if
// sample channel: mode, read status and three raw axis readings
// ----------------------------------------------------------------------------
interface comp_in_if
    import comp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic                    sample_ok;
    logic signed [MAG_W-1:0] mag_x;
    logic signed [MAG_W-1:0] mag_y;
    logic signed [MAG_W-1:0] mag_z;

    modport source (output valid, mode, sample_ok, mag_x, mag_y, mag_z, input ready);
    modport sink   (input valid, mode, sample_ok, mag_x, mag_y, mag_z, output ready);
endinterface

### hdl/comp_out_if.sv
// ----------------------------------------------------------------------------
// comp_out_if
// result channel: heading and status flags
// ----------------------------------------------------------------------------
interface comp_out_if
    import comp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] heading;
    logic              heading_valid;
    logic              scales_updated;

    modport source (output valid, heading, heading_valid, scales_updated, input ready);
    modport sink   (input valid, heading, heading_valid, scales_updated, output ready);
endinterface

### hdl/comp_mul.sv
// ----------------------------------------------------------------------------
// comp_mul
// bit-serial shift-add multiplier, signed operand times unsigned scale
// ----------------------------------------------------------------------------
module comp_mul
    import comp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [CAL_W-1:0]  i_a,
    input  logic [SCALE_W-1:0]       i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_p
);
    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_a;
    logic [SCALE_W-1:0] r_b;
    logic [MCNT_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= {{(PROD_W-CAL_W){i_a[CAL_W-1]}}, i_a};
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one scale bit per cycle, lsb first
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MCNT_W'(SCALE_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = signed'(r_acc);
endmodule

### hdl/comp_div.sv
// ----------------------------------------------------------------------------
// comp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module comp_div
    import comp_pkg::*;
#(
    parameter int NUM_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // dividend bits shift out the top while quotient bits shift in
                if (w_ge) begin
                    r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                end else begin
                    r_rem <= w_trial[DEN_W-1:0];
                end
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

### hdl/comp_cordic.sv
// ----------------------------------------------------------------------------
// comp_cordic
// vectoring cordic, one micro-rotation per cycle, then angle to heading
// ----------------------------------------------------------------------------
module comp_cordic
    import comp_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [PROD_W-1:0] i_x,
    input  logic signed [PROD_W-1:0] i_y,
    output logic                     o_done,
    output logic [HEAD_W-1:0]        o_heading
);
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic [ANG_W-1:0]         r_z;
    logic [STEP_W-1:0]        r_i;
    logic                     r_run;
    logic                     r_fin;
    logic                     r_done;
    logic [HEAD_W-1:0]        r_heading;
    logic signed [CORD_W-1:0] w_xe;
    logic signed [CORD_W-1:0] w_ye;
    logic signed [CORD_W-1:0] w_xs;
    logic signed [CORD_W-1:0] w_ys;
    logic [47:0]              w_prod;
    logic [15:0]              w_h;

    assign w_xe   = CORD_W'(i_x);
    assign w_ye   = CORD_W'(i_y);
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_prod = 48'(r_z) * 48'(HEADING_TURN) + 48'(HALF_TURN);
    assign w_h    = w_prod[47:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == '0 && i_y == '0) begin
                    r_z   <= '0;
                    r_fin <= 1'b1;
                end else begin
                    // left half plane: rotate by half a turn first
                    if (i_x < 0) begin
                        r_x <= -w_xe;
                        r_y <= -w_ye;
                        r_z <= HALF_TURN;
                    end else begin
                        r_x <= w_xe;
                        r_y <= w_ye;
                        r_z <= '0;
                    end
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                if (r_y >= 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + ATAN_TURNS[r_i];
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - ATAN_TURNS[r_i];
                end
                r_i <= r_i + 1'b1;
                if (r_i == STEP_W'(STEPS-1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                // round to nearest 1/64 degree, full turn wraps to zero
                r_heading <= (w_h >= 16'(HEADING_TURN)) ? '0 : w_h[HEAD_W-1:0];
                r_fin     <= 1'b0;
                r_done    <= 1'b1;
            end
        end
    end

    assign o_done    = r_done;
    assign o_heading = r_heading;
endmodule

### hdl/compass_calibrate_and_heading.sv
// ----------------------------------------------------------------------------
// compass_calibrate_and_heading
// min/max magnetometer calibration and cordic heading
// ----------------------------------------------------------------------------
// One transaction at a time. Start, sample and bad heading samples go
// from accept straight to the result handoff. Finish with all ranges
// positive runs the serial divider once per axis, otherwise it goes
// straight to the handoff. A good heading sample runs the serial
// multiplier, CORDIC_STEPS micro-rotations and the rounding step. The
// result sits in an output register, so a new sample is taken while the
// previous result waits.
module compass_calibrate_and_heading
    import comp_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int SCALE_FRAC_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    comp_in_if.sink    i_in,
    comp_out_if.source o_out
);
    localparam int NUM_W = SUM_W + SCALE_FRAC_BITS + 2;
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_CORD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;

    logic signed [MAG_W-1:0]  r_min   [3];
    logic signed [MAG_W-1:0]  r_max   [3];
    logic signed [OFFD_W-1:0] r_offd  [3];
    logic [SCALE_W-1:0]       r_scale [3];
    logic [RANGE_W-1:0]       r_d     [3];
    logic [1:0]               r_ax;
    logic signed [MAG_W-1:0]  r_mx;
    logic signed [MAG_W-1:0]  r_my;
    logic                     r_div_go;
    logic                     r_mul_go;
    logic [HEAD_W-1:0]        r_p_heading;
    logic                     r_p_hv;
    logic                     r_p_su;
    logic                     r_out_valid;
    logic [HEAD_W-1:0]        r_heading;
    logic                     r_hv;
    logic                     r_su;

    logic signed [OFFD_W-1:0] w_diff [3];
    logic                     w_allpos;
    logic                     w_accept;
    logic signed [MAG_W-1:0]  w_m [3];
    logic [SUM_W-1:0]         w_sum;
    logic [SUM_W-1:0]         w_d3;
    logic [NUM_W-1:0]         w_num;
    logic [DEN_W-1:0]         w_den;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quo;
    logic [SCALE_W-1:0]       w_scale_new;
    logic signed [CAL_W-1:0]  w_cal_x;
    logic signed [CAL_W-1:0]  w_cal_y;
    logic                     w_mul_done;
    logic                     w_mul_done_y;
    logic signed [PROD_W-1:0] w_px;
    logic signed [PROD_W-1:0] w_py;
    logic                     w_cord_start;
    logic                     w_cord_done;
    logic [HEAD_W-1:0]        w_cord_heading;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_m[0]   = i_in.mag_x;
    assign w_m[1]   = i_in.mag_y;
    assign w_m[2]   = i_in.mag_z;

    always_comb begin
        w_allpos = 1'b1;
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = {r_max[k][MAG_W-1], r_max[k]} - {r_min[k][MAG_W-1], r_min[k]};
            if (w_diff[k][OFFD_W-1] || w_diff[k] == '0) begin
                w_allpos = 1'b0;
            end
        end
    end

    // scale = round(sum * 2^f / (3 d)) as floor((2 sum 2^f + 3d) / 6d)
    assign w_sum = SUM_W'(r_d[0]) + SUM_W'(r_d[1]) + SUM_W'(r_d[2]);
    assign w_d3  = SUM_W'(r_d[r_ax]) + (SUM_W'(r_d[r_ax]) << 1);
    assign w_num = (NUM_W'(w_sum) << (SCALE_FRAC_BITS + 1)) + NUM_W'(w_d3);
    assign w_den = DEN_W'(w_d3) << 1;

    assign w_scale_new = (|w_quo[NUM_W-1:SCALE_W]) ? SCALE_TOP : w_quo[SCALE_W-1:0];

    assign w_cal_x = {r_mx[MAG_W-1], r_mx, 1'b0} - {r_offd[0][OFFD_W-1], r_offd[0]};
    assign w_cal_y = {r_my[MAG_W-1], r_my, 1'b0} - {r_offd[1][OFFD_W-1], r_offd[1]};

    assign w_cord_start = w_mul_done && (r_state == S_MUL);

    comp_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    comp_mul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_cal_x),
        .i_b     (r_scale[0]),
        .o_done  (w_mul_done),
        .o_p     (w_px)
    );

    comp_mul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_cal_y),
        .i_b     (r_scale[1]),
        .o_done  (w_mul_done_y),
        .o_p     (w_py)
    );

    comp_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cord_start),
        .i_x       (w_px),
        .i_y       (w_py),
        .o_done    (w_cord_done),
        .o_heading (w_cord_heading)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
            r_mul_go    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_min[k]   <= 16'sh7FFF;
                r_max[k]   <= 16'sh8000;
                r_offd[k]  <= '0;
                r_scale[k] <= SCALE_ONE;
            end
        end else begin
            r_div_go <= 1'b0;
            r_mul_go <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mx        <= i_in.mag_x;
                        r_my        <= i_in.mag_y;
                        r_p_heading <= '0;
                        r_p_hv      <= 1'b0;
                        r_p_su      <= 1'b0;
                        r_state     <= S_DONE;
                        case (t_mode'(i_in.mode))
                            MODE_START: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_min[k] <= 16'sh7FFF;
                                    r_max[k] <= 16'sh8000;
                                end
                            end
                            MODE_SAMPLE: begin
                                if (i_in.sample_ok) begin
                                    for (int k = 0; k < 3; k++) begin
                                        if (w_m[k] < r_min[k]) begin
                                            r_min[k] <= w_m[k];
                                        end
                                        if (w_m[k] > r_max[k]) begin
                                            r_max[k] <= w_m[k];
                                        end
                                    end
                                end
                            end
                            MODE_FINISH: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_offd[k] <= {r_max[k][MAG_W-1], r_max[k]}
                                               + {r_min[k][MAG_W-1], r_min[k]};
                                    r_d[k]    <= w_diff[k][RANGE_W-1:0];
                                end
                                if (w_allpos) begin
                                    r_ax     <= 2'd0;
                                    r_div_go <= 1'b1;
                                    r_state  <= S_DIV;
                                end
                            end
                            MODE_HEADING: begin
                                if (i_in.sample_ok) begin
                                    r_mul_go <= 1'b1;
                                    r_state  <= S_MUL;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_scale[r_ax] <= w_scale_new;
                        if (r_ax == 2'd2) begin
                            r_p_su  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_ax     <= r_ax + 1'b1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (w_cord_done) begin
                        r_p_heading <= w_cord_heading;
                        r_p_hv      <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_heading   <= r_p_heading;
                        r_hv        <= r_p_hv;
                        r_su        <= r_p_su;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.heading        = r_heading;
    assign o_out.heading_valid  = r_hv;
    assign o_out.scales_updated = r_su;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.heading_valid && o_out.scales_updated))
        else $error("heading and scale flags both set");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.heading < HEADING_TURN)
                        && (o_out.heading_valid || o_out.heading == '0))
        else $error("heading out of range or set while invalid");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("second transaction taken while busy");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside finish sequence");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done == w_mul_done_y)
        else $error("axis multipliers out of step");
endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives compass samples through calibration and heading, checks every result
// against typed-in rows or an in-bench model of trackers, scale divider, cordic
// ----------------------------------------------------------------------------
module testbench;
    import comp_pkg::*;

    typedef struct packed {
        logic [1:0]              mode;
        logic                    ok;
        logic signed [MAG_W-1:0] x;
        logic signed [MAG_W-1:0] y;
        logic signed [MAG_W-1:0] z;
    } t_sample;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              hvalid;
        logic              supd;
    } t_result;

    // directed row: known marks whether the typed-in result replaces prediction
    typedef struct packed {
        t_sample s;
        logic    known;
        t_result r;
    } t_row;

    localparam int NUM_RANDOM = 2000;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic i_clk;
    logic i_rst_n;
    comp_in_if  in_ch ();
    comp_out_if out_ch ();

    compass_calibrate_and_heading dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // model state
    int    trk_min [3];
    int    trk_max [3];
    int    off_dbl [3];
    int    scl [3];

    t_result expected_results [$];
    int      mismatches;
    int      cycles;
    bit      long_hold;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [HEAD_W-1:0] cordic_heading(longint vx, longint vy);
        logic [31:0] ang;
        longint      sx;
        longint      sy;
        logic [63:0] h;
        ang = '0;
        if (vx == 0 && vy == 0) return '0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            ang = HALF_TURN;
        end
        for (int i = 0; i < 16; i++) begin
            sx = shr_arith(vx, i);
            sy = shr_arith(vy, i);
            if (vy >= 0) begin
                vx = vx + sy;
                vy = vy - sx;
                ang = ang + ATAN_TURNS[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                ang = ang - ATAN_TURNS[i];
            end
        end
        h = (64'(ang) * 64'd23040 + 64'h8000_0000) >> 32;
        if (h >= 64'd23040) h = '0;
        return h[HEAD_W-1:0];
    endfunction

    function automatic t_result predict_compass(t_sample s);
        t_result   r;
        int        m [3];
        int        d [3];
        bit        all_pos;
        longint    total;
        longint    den;
        longint    q;
        longint    cx;
        longint    cy;
        r = '0;
        m[0] = s.x;
        m[1] = s.y;
        m[2] = s.z;
        case (t_mode'(s.mode))
            MODE_START: begin
                for (int k = 0; k < 3; k++) begin
                    trk_min[k] = 32767;
                    trk_max[k] = -32768;
                end
            end
            MODE_SAMPLE: begin
                if (s.ok) begin
                    for (int k = 0; k < 3; k++) begin
                        if (m[k] < trk_min[k]) trk_min[k] = m[k];
                        if (m[k] > trk_max[k]) trk_max[k] = m[k];
                    end
                end
            end
            MODE_FINISH: begin
                all_pos = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    off_dbl[k] = trk_max[k] + trk_min[k];
                    d[k] = trk_max[k] - trk_min[k];
                    if (d[k] <= 0) all_pos = 1'b0;
                end
                if (all_pos) begin
                    total = longint'(d[0]) + d[1] + d[2];
                    for (int k = 0; k < 3; k++) begin
                        den = 3 * longint'(d[k]);
                        q = ((total << 12) * 2 + den) / (2 * den);
                        scl[k] = (q > 65535) ? 65535 : int'(q);
                    end
                    r.supd = 1'b1;
                end
            end
            default: begin
                if (s.ok) begin
                    cx = (2 * longint'(m[0]) - off_dbl[0]) * scl[0];
                    cy = (2 * longint'(m[1]) - off_dbl[1]) * scl[1];
                    r.heading = cordic_heading(cx, cy);
                    r.hvalid = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // valid stays high between back to back transactions
    task automatic send_sample(t_sample s);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= s.mode;
        in_ch.sample_ok <= s.ok;
        in_ch.mag_x     <= s.x;
        in_ch.mag_y     <= s.y;
        in_ch.mag_z     <= s.z;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic t_sample make_sample(logic [1:0] md, int ok,
                                            int x, int y, int z);
        t_sample s;
        s.mode = md;
        s.ok   = ok[0];
        s.x    = x[15:0];
        s.y    = y[15:0];
        s.z    = z[15:0];
        return s;
    endfunction

    function automatic t_sample rand_sample(logic [1:0] md, int spread);
        int ctr;
        ctr = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 2000)) - 1000;
        return make_sample(md, $urandom_range(0, 15) != 0,
            ctr + int'($urandom_range(0, 2 * spread)) - spread,
            ctr + int'($urandom_range(0, 2 * spread)) - spread,
            int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // result checker, runs on accepted results at each edge
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.heading, out_ch.heading_valid, out_ch.scales_updated};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp heading %0d hv %0b su %0b, got %0d %0b %0b",
                            exp_r.heading, exp_r.hvalid, exp_r.supd,
                            got.heading, got.hvalid, got.supd);
                end
            end
        end
    end

    // receiver with random stalls and long holds
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_row    rows [$];
        t_sample s;
        t_result r;
        int      spread;
        mismatches = 0;
        long_hold = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_START;
        in_ch.sample_ok <= 1'b0;
        in_ch.mag_x <= '0;
        in_ch.mag_y <= '0;
        in_ch.mag_z <= '0;
        i_rst_n <= 1'b0;
        for (int k = 0; k < 3; k++) begin
            trk_min[k] = 32767;
            trk_max[k] = -32768;
            off_dbl[k] = 0;
            scl[k] = 4096;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // heading after reset: (1,0) east of nothing gives 0, (0,1) quarter turn
        rows.push_back({make_sample(MODE_HEADING, 1, 1, 0, 0), 1'b1, 15'd0, 1'b1, 1'b0});
        rows.push_back({make_sample(MODE_HEADING, 1, 0, 1, 0), 1'b1, 15'd5760, 1'b1, 1'b0});
        rows.push_back({make_sample(MODE_HEADING, 1, 0, 0, 0), 1'b1, 15'd0, 1'b1, 1'b0});
        rows.push_back({make_sample(MODE_HEADING, 0, 5, 5, 5), 1'b1, 15'd0, 1'b0, 1'b0});
        rows.push_back({make_sample(MODE_HEADING, 1, -1, 0, 0), 1'b1, 15'd11520, 1'b1, 1'b0});
        // finish without samples keeps scales
        rows.push_back({make_sample(MODE_FINISH, 1, 0, 0, 0), 1'b1, 15'd0, 1'b0, 1'b0});
        rows.push_back({make_sample(MODE_HEADING, 1, -32768, 32767, 0), 1'b0, 17'd0});
        rows.push_back({make_sample(MODE_START, 1, 7, 7, 7), 1'b1, 15'd0, 1'b0, 1'b0});
        rows.push_back({make_sample(MODE_SAMPLE, 1, -32768, -32768, -32768), 1'b1, 17'd0});
        rows.push_back({make_sample(MODE_SAMPLE, 0, 9, 9, 9), 1'b1, 17'd0});
        rows.push_back({make_sample(MODE_SAMPLE, 1, 32767, 32767, 32767), 1'b1, 17'd0});
        rows.push_back({make_sample(MODE_FINISH, 0, 0, 0, 0), 1'b0, 17'd0});
        rows.push_back({make_sample(MODE_HEADING, 1, 32767, -32768, 0), 1'b0, 17'd0});
        rows.push_back({make_sample(MODE_HEADING, 1, -32768, -1, 0), 1'b0, 17'd0});
        // one axis flat: scales kept
        rows.push_back({make_sample(MODE_START, 0, 0, 0, 0), 1'b1, 17'd0});
        rows.push_back({make_sample(MODE_SAMPLE, 1, -100, 5, 3), 1'b1, 17'd0});
        rows.push_back({make_sample(MODE_SAMPLE, 1, 100, 9, 3), 1'b1, 17'd0});
        rows.push_back({make_sample(MODE_FINISH, 1, 0, 0, 0), 1'b1, 15'd0, 1'b0, 1'b0});
        // tiny ranges against a huge one saturate the scale
        rows.push_back({make_sample(MODE_SAMPLE, 1, 32767, 10, 4), 1'b0, 17'd0});
        rows.push_back({make_sample(MODE_FINISH, 1, 0, 0, 0), 1'b0, 17'd0});
        rows.push_back({make_sample(MODE_HEADING, 1, 16000, 8, 0), 1'b0, 17'd0});
        rows.push_back({make_sample(MODE_HEADING, 1, 0, 7, 0), 1'b0, 17'd0});

        foreach (rows[i]) begin
            r = predict_compass(rows[i].s);
            expected_results.push_back(rows[i].known ? rows[i].r : r);
            send_sample(rows[i].s);
        end

        // random part: mostly start, samples, finish, headings
        for (int n = 0; n < NUM_RANDOM; ) begin
            if (n > 300 && n < 340) long_hold = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                s = make_sample(2'($urandom_range(0, 3)), $urandom_range(0, 1),
                    $urandom, $urandom, $urandom);
                expected_results.push_back(predict_compass(s));
                send_sample(s);
                n++;
                continue;
            end
            spread = ($urandom_range(0, 7) == 0) ? 32767 - 1000 : $urandom_range(1, 3000);
            s = make_sample(MODE_START, $urandom_range(0, 1), $urandom, $urandom, $urandom);
            expected_results.push_back(predict_compass(s));
            send_sample(s);
            n++;
            repeat ($urandom_range(1, 10)) begin
                s = rand_sample(MODE_SAMPLE, spread);
                expected_results.push_back(predict_compass(s));
                send_sample(s);
                n++;
            end
            s = make_sample(MODE_FINISH, $urandom_range(0, 1), $urandom, $urandom, $urandom);
            expected_results.push_back(predict_compass(s));
            send_sample(s);
            n++;
            repeat ($urandom_range(1, 10)) begin
                s = rand_sample(MODE_HEADING, spread);
                expected_results.push_back(predict_compass(s));
                send_sample(s);
                n++;
            end
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
